FILE: hw/rtl/pild_pkg.sv
// ----------------------------------------------------------------------------
// pild_pkg
// Shared widths, defaults and status codes for the positional insert list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pild_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int POS_W        = 8;
  localparam int VAL_W        = 32;
  localparam int STATUS_W     = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pild_ram.sv
// ----------------------------------------------------------------------------
// pild_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pild_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/positional_insert_list_dump_core.sv
// ----------------------------------------------------------------------------
// positional_insert_list_dump_core
// Ordered list of signed values with insert at a position and a full dump
// (front to back, then back to front) after every accepted insert.
// ----------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  --------+----------------------------------------+--------------------------
//  input   | in_position, in_item_value             | start & !busy
//  result  | out_status, out_reverse_pass,          | out_valid, one cycle,
//          | out_entry_value, out_last_item         | no back-pressure
//
//  A good insert shifts the tail up one place with one RAM read per cycle,
//  one write stores the value, then 2*len reads stream the dump (len counts
//  the new entry); an append skips the shift. A refused insert gives a single
//  result. The single read and write ports of the list RAM set this pace.
//  Reset empties the list; RAM contents are not cleared.
//  Results cannot be stalled; busy holds off new items while an insert or its dump runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_list_dump_core #(
  parameter int CAPACITY = pild_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pild_pkg::POS_W-1:0]    in_position,
  input  wire logic signed [pild_pkg::VAL_W-1:0] in_item_value,
  output logic                               out_valid,
  output logic [pild_pkg::STATUS_W-1:0]      out_status,
  output logic                               out_reverse_pass,
  output logic signed [pild_pkg::VAL_W-1:0]  out_entry_value,
  output logic                               out_last_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_FWD,
    S_REV
  } state_t;

  state_t                        state_r;
  logic [LW-1:0]                 len_r;
  logic [AW-1:0]                 pos_r;
  logic [pild_pkg::VAL_W-1:0]    val_r;
  logic [AW-1:0]                 idx_r;
  logic                          wpend_r;
  logic [AW-1:0]                 waddr_r;
  logic                          pend_r;
  logic                          prev_r;
  logic                          plast_r;
  logic                          err_r;
  pild_pkg::status_t             est_r;

  logic                          accept;
  logic [LW-1:0]                 len_m1;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [pild_pkg::VAL_W-1:0]    ram_wdata;
  logic [pild_pkg::VAL_W-1:0]    ram_rdata;

  assign busy   = (state_r != S_IDLE) || pend_r;
  assign accept = start && !busy;
  assign len_m1 = len_r - LW'(1);

  assign ram_we    = wpend_r || (state_r == S_PUT);
  assign ram_waddr = wpend_r ? waddr_r : pos_r;
  assign ram_wdata = wpend_r ? ram_rdata : val_r;

  pild_ram #(
    .WIDTH (pild_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      wpend_r <= 1'b0;
      pend_r  <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      pend_r  <= 1'b0;
      err_r   <= 1'b0;
      wpend_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_position > pild_pkg::POS_W'(len_r)) begin
              err_r <= 1'b1;
              est_r <= pild_pkg::ST_BEYOND;
            end else if (len_r >= CAP_L) begin
              err_r <= 1'b1;
              est_r <= pild_pkg::ST_FULL;
            end else begin
              pos_r <= in_position[AW-1:0];
              val_r <= in_item_value;
              idx_r <= len_m1[AW-1:0];
              if (in_position == pild_pkg::POS_W'(len_r)) begin
                state_r <= S_PUT;
              end else begin
                state_r <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          // read entry idx, write it one place up on the next cycle
          wpend_r <= 1'b1;
          waddr_r <= idx_r + AW'(1);
          if (idx_r == pos_r) begin
            state_r <= S_PUT;
          end else begin
            idx_r <= idx_r - AW'(1);
          end
        end
        S_PUT: begin
          if (!wpend_r) begin
            len_r   <= len_r + LW'(1);
            idx_r   <= '0;
            state_r <= S_FWD;
          end
        end
        S_FWD: begin
          pend_r  <= 1'b1;
          prev_r  <= 1'b0;
          plast_r <= 1'b0;
          if (idx_r == len_m1[AW-1:0]) begin
            state_r <= S_REV;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        S_REV: begin
          pend_r  <= 1'b1;
          prev_r  <= 1'b1;
          plast_r <= (idx_r == '0);
          if (idx_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r - AW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = pend_r || err_r;
  assign out_status       = err_r ? est_r : pild_pkg::ST_OK;
  assign out_reverse_pass = pend_r && prev_r;
  assign out_entry_value  = pend_r ? ram_rdata : '0;
  assign out_last_item    = err_r || (pend_r && plast_r);

endmodule

`default_nettype wire

FILE: dv/positional_insert_list_dump_checker.sv
// ----------------------------------------------------------------------------
// positional_insert_list_dump_checker
// Watches the item and result channels of the positional insert list. It
// keeps its own copy of the list and length, and turns every accepted item
// into the dump or refusal it should cause. It compares each result against
// the oldest expected one and counts mismatches for the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_insert_list_dump_checker #(
  parameter int CAPACITY = pild_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic [pild_pkg::POS_W-1:0]        in_position,
  input  wire logic signed [pild_pkg::VAL_W-1:0] in_item_value,
  input  wire logic                              out_valid,
  input  wire logic [pild_pkg::STATUS_W-1:0]     out_status,
  input  wire logic                              out_reverse_pass,
  input  wire logic signed [pild_pkg::VAL_W-1:0] out_entry_value,
  input  wire logic                              out_last_item,
  output int                                     fail_count,
  output int                                     pending
);

  typedef struct packed {
    logic [pild_pkg::STATUS_W-1:0]     status;
    logic                              reverse_pass;
    logic signed [pild_pkg::VAL_W-1:0] entry_value;
    logic                              last_item;
  } dump_entry_t;

  logic signed [pild_pkg::VAL_W-1:0] list_mem [CAPACITY];
  int                                list_len = 0;
  dump_entry_t                       dump_q[$];
  int                                fails = 0;
  int                                queued = 0;

  assign fail_count = fails;
  assign pending    = queued;

  task automatic push_result(input pild_pkg::status_t st, input logic rev,
                             input logic signed [pild_pkg::VAL_W-1:0] v,
                             input logic last);
    dump_entry_t e;
    e.status       = st;
    e.reverse_pass = rev;
    e.entry_value  = v;
    e.last_item    = last;
    dump_q.push_back(e);
  endtask

  task automatic insert_and_dump(input int pos,
                                 input logic signed [pild_pkg::VAL_W-1:0] val);
    int i;
    if (pos > list_len) begin
      push_result(pild_pkg::ST_BEYOND, 1'b0, '0, 1'b1);
    end else if (list_len >= CAPACITY) begin
      push_result(pild_pkg::ST_FULL, 1'b0, '0, 1'b1);
    end else begin
      for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
      list_mem[pos] = val;
      list_len++;
      for (i = 0; i < list_len; i++)
        push_result(pild_pkg::ST_OK, 1'b0, list_mem[i], 1'b0);
      for (i = list_len; i > 0; i--)
        push_result(pild_pkg::ST_OK, 1'b1, list_mem[i-1], i == 1);
    end
  endtask

  always @(posedge clk) begin
    dump_entry_t got;
    dump_entry_t want;
    if (!rst_n) begin
      list_len = 0;
      dump_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        got = {out_status, out_reverse_pass, out_entry_value, out_last_item};
        if (dump_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected result: status=%0d rev=%b value=%0d last=%b",
                     $realtime, got.status, got.reverse_pass, got.entry_value,
                     got.last_item);
        end else begin
          want = dump_q.pop_front();
          if (got.status !== want.status || got.reverse_pass !== want.reverse_pass ||
              got.entry_value !== want.entry_value || got.last_item !== want.last_item)
          begin
            fails++;
            if (fails <= 10)
              $display({"[%0t] mismatch: exp status=%0d rev=%b value=%0d last=%b",
                        " | got status=%0d rev=%b value=%0d last=%b"},
                       $realtime, want.status, want.reverse_pass, want.entry_value,
                       want.last_item, got.status, got.reverse_pass, got.entry_value,
                       got.last_item);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        insert_and_dump(int'(in_position), in_item_value);
    end
    queued = dump_q.size();
  end

endmodule

FILE: dv/positional_insert_list_dump_core_tb.sv
// ----------------------------------------------------------------------------
// positional_insert_list_dump_core_tb
// Drives insert items into the positional insert list: a directed opening
// with edge positions and extreme values, then random bursts that fill the
// list and keep probing it with out-of-range and full-list refusals. The
// checker beside the block predicts and compares every dump result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_insert_list_dump_core_tb;

  localparam int CAPACITY   = pild_pkg::CAPACITY_DEF;
  localparam int ITEM_COUNT = 460;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic [pild_pkg::POS_W-1:0]        in_position = '0;
  logic signed [pild_pkg::VAL_W-1:0] in_item_value = '0;
  logic                              busy;
  logic                              out_valid;
  logic [pild_pkg::STATUS_W-1:0]     out_status;
  logic                              out_reverse_pass;
  logic signed [pild_pkg::VAL_W-1:0] out_entry_value;
  logic                              out_last_item;
  int                                fail_count;
  int                                pending;

  int list_fill = 0;
  int sent = 0;
  int ok_count = 0;
  int beyond_count = 0;
  int full_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  positional_insert_list_dump_core #(.CAPACITY(CAPACITY)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_reverse_pass (out_reverse_pass),
    .out_entry_value  (out_entry_value),
    .out_last_item    (out_last_item)
  );

  positional_insert_list_dump_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_reverse_pass (out_reverse_pass),
    .out_entry_value  (out_entry_value),
    .out_last_item    (out_last_item),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  task automatic send_insert(input int pos, input logic signed [pild_pkg::VAL_W-1:0] val);
    start         <= 1'b1;
    in_position   <= pild_pkg::POS_W'(pos);
    in_item_value <= val;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
    if (pos > list_fill) begin
      beyond_count++;
    end else if (list_fill >= CAPACITY) begin
      full_count++;
    end else begin
      list_fill++;
      ok_count++;
    end
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic signed [pild_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (list_fill < CAPACITY) begin
      if (r < 80) return $urandom_range(0, list_fill);
      if (r < 90) return list_fill + 1;
    end else begin
      if (r < 50) return $urandom_range(0, list_fill);
      if (r < 65) return list_fill + 1;
    end
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int burst;
    int gap;
    bit full_probed;
    full_probed = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_insert(255, 32'sd5);
    send_insert(1, 32'sd7);
    send_insert(0, 32'h8000_0000);
    send_insert(1, 32'h7FFF_FFFF);
    send_insert(0, '1);
    send_insert(2, '0);
    send_insert(5, 32'sd12);
    send_insert(4, 32'sd1);
    send_insert(128, 32'h5555_5555);
    send_insert(0, 32'hAAAA_AAAA);
    send_insert(6, 32'hAAAA_AAAA);
    drain_results();

    while (sent < ITEM_COUNT) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < ITEM_COUNT) begin
          if (list_fill == CAPACITY && !full_probed) begin
            drain_results();
            send_insert(CAPACITY, pick_value());
            send_insert(0, pick_value());
            send_insert(CAPACITY + 1, pick_value());
            full_probed = 1'b1;
          end else begin
            send_insert(pick_position(), pick_value());
          end
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_cycles(gap);
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("Sent %0d items: %0d inserts, %0d out-of-range and %0d full-list refusals.",
             sent, ok_count, beyond_count, full_count);
    $display("List grew to %0d of %0d entries; both dump directions checked after each insert.",
             list_fill, CAPACITY);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
